FILE: src/eyv_pkg.sv
// Package for the Euler YXZ view matrix core: widths, fixed-point constants
// and the shared Q2.14 product helper. No dependencies.
package eyv_pkg;

   localparam int AngW  = 16;
   localparam int EntW  = 16;
   localparam int PosW  = 32;
   localparam int QBits = 14;
   localparam logic signed [17:0] OneQ14  = 18'sd16384;
   localparam logic signed [17:0] HalfQ14 = 18'sd8192;

   // Signed Q2.14 value (range -16384..16384) widened to 18 bits
   typedef logic signed [17:0] q14_type;

   // Rounded Q2.14 product: floor((a*b + 8192) / 2^14)
   function automatic q14_type mul14(input q14_type a, input q14_type b);
      logic signed [35:0] p;
      p = a * b + 36'sd8192;
      return q14_type'(p >>> QBits);
   endfunction

   // Clamp a sum to -16384..16384
   function automatic q14_type clamp_entry(input logic signed [18:0] x);
      q14_type r;
      if (x > 19'sd16384) begin
         r = OneQ14;
      end else if (x < -19'sd16384) begin
         r = -OneQ14;
      end else begin
         r = q14_type'(x);
      end
      return r;
   endfunction

endpackage

FILE: src/euler_yxz_view_matrix_core.sv
// Top level of the Euler YXZ view matrix core: sines, basis rows, translation.
// Uses eyv_pkg and eyv_sine.
// Throughput: one item per cycle; the pipeline advances whenever its last
// stage is empty or the result is taken (ready is shared by all stages).
// Reset clears only the stage valid bits; payload registers are not reset.
module euler_yxz_view_matrix_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   input  logic [15:0]         req_angle_x,
   input  logic [15:0]         req_angle_y,
   input  logic [15:0]         req_angle_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_u_x,
   output logic signed [15:0]  rsp_u_y,
   output logic signed [15:0]  rsp_u_z,
   output logic signed [15:0]  rsp_v_x,
   output logic signed [15:0]  rsp_v_y,
   output logic signed [15:0]  rsp_v_z,
   output logic signed [15:0]  rsp_w_x,
   output logic signed [15:0]  rsp_w_y,
   output logic signed [15:0]  rsp_w_z,
   output logic signed [31:0]  rsp_trans_u,
   output logic signed [31:0]  rsp_trans_v,
   output logic signed [31:0]  rsp_trans_w
);

   localparam int Depth = 10;
   typedef eyv_pkg::q14_type q_type;

   logic [Depth-1:0] vld_ff;
   logic adv;

   // stall all stages only when the output holds an untaken item
   assign adv       = !vld_ff[Depth-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Depth-2:0], req_valid};
      end
   end

   // stages 1-4: six sine pipelines, cosine as sine of angle plus a quarter
   q_type s1, c1, s2, c2, s3, c3;
   eyv_sine u_s1 (.clock, .adv, .ang(req_angle_y), .sin_out(s1));
   eyv_sine u_c1 (.clock, .adv, .ang(req_angle_y + 16'd16384), .sin_out(c1));
   eyv_sine u_s2 (.clock, .adv, .ang(req_angle_x), .sin_out(s2));
   eyv_sine u_c2 (.clock, .adv, .ang(req_angle_x + 16'd16384), .sin_out(c2));
   eyv_sine u_s3 (.clock, .adv, .ang(req_angle_z), .sin_out(s3));
   eyv_sine u_c3 (.clock, .adv, .ang(req_angle_z + 16'd16384), .sin_out(c3));

   // carry position alongside (4 sine stages + 2 product stages)
   logic signed [31:0] px_ff [6], py_ff [6], pz_ff [6];
   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff[0] <= req_pos_x;
         py_ff[0] <= req_pos_y;
         pz_ff[0] <= req_pos_z;
         for (int i = 1; i < 6; i++) begin
            px_ff[i] <= px_ff[i-1];
            py_ff[i] <= py_ff[i-1];
            pz_ff[i] <= pz_ff[i-1];
         end
      end
   end

   // stage 5: first products
   q_type c1c3_ff, s1s2_ff, c2s3_ff, c1s2_ff, c3s1_ff, c1s3_ff, c2c3_ff, s1s3_ff;
   q_type c2s1_ff, c1c2_ff, s2_5_ff, s3_5_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         c1c3_ff <= eyv_pkg::mul14(c1, c3);
         s1s2_ff <= eyv_pkg::mul14(s1, s2);
         c2s3_ff <= eyv_pkg::mul14(c2, s3);
         c1s2_ff <= eyv_pkg::mul14(c1, s2);
         c3s1_ff <= eyv_pkg::mul14(c3, s1);
         c1s3_ff <= eyv_pkg::mul14(c1, s3);
         c2c3_ff <= eyv_pkg::mul14(c2, c3);
         s1s3_ff <= eyv_pkg::mul14(s1, s3);
         c2s1_ff <= eyv_pkg::mul14(c2, s1);
         c1c2_ff <= eyv_pkg::mul14(c1, c2);
         s2_5_ff <= s2;
         s3_5_ff <= s3;
      end
   end

   // stage 6: three-factor terms, sums and clamp
   q_type m_ff [9];
   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff[0] <= eyv_pkg::clamp_entry(19'(c1c3_ff) + 19'(eyv_pkg::mul14(s1s2_ff, s3_5_ff)));
         m_ff[1] <= c2s3_ff;
         m_ff[2] <= eyv_pkg::clamp_entry(19'(eyv_pkg::mul14(c1s2_ff, s3_5_ff)) - 19'(c3s1_ff));
         m_ff[3] <= eyv_pkg::clamp_entry(19'(eyv_pkg::mul14(c3s1_ff, s2_5_ff)) - 19'(c1s3_ff));
         m_ff[4] <= c2c3_ff;
         m_ff[5] <= eyv_pkg::clamp_entry(19'(eyv_pkg::mul14(c1c3_ff, s2_5_ff)) + 19'(s1s3_ff));
         m_ff[6] <= c2s1_ff;
         m_ff[7] <= eyv_pkg::clamp_entry(-19'(s2_5_ff));
         m_ff[8] <= c1c2_ff;
      end
   end

   // stage 7: entry by position products (18 x 32)
   logic signed [49:0] pr_ff [9];
   q_type m7_ff [9];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            pr_ff[3*r]   <= m_ff[3*r]   * px_ff[5];
            pr_ff[3*r+1] <= m_ff[3*r+1] * py_ff[5];
            pr_ff[3*r+2] <= m_ff[3*r+2] * pz_ff[5];
         end
         m7_ff <= m_ff;
      end
   end

   // stage 8: sum the three products of each row
   logic signed [51:0] sum_ff [3];
   q_type m8_ff [9];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            sum_ff[r] <= 52'(pr_ff[3*r]) + 52'(pr_ff[3*r+1]) + 52'(pr_ff[3*r+2]);
         end
         m8_ff <= m7_ff;
      end
   end

   // stage 9: negate, round and shift
   logic signed [38:0] sh_ff [3];
   q_type m9_ff [9];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            sh_ff[r] <= 39'((53'sd8192 - 53'(sum_ff[r])) >>> eyv_pkg::QBits);
         end
         m9_ff <= m8_ff;
      end
   end

   // stage 10: saturate into the output register
   logic signed [31:0] tr_ff [3];
   q_type mo_ff [9];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            if (sh_ff[r] > 39'sd2147483647) begin
               tr_ff[r] <= 32'sh7FFFFFFF;
            end else if (sh_ff[r] < -39'sd2147483648) begin
               tr_ff[r] <= 32'sh80000000;
            end else begin
               tr_ff[r] <= 32'(sh_ff[r]);
            end
         end
         mo_ff <= m9_ff;
      end
   end

   assign rsp_u_x = 16'(mo_ff[0]);
   assign rsp_u_y = 16'(mo_ff[1]);
   assign rsp_u_z = 16'(mo_ff[2]);
   assign rsp_v_x = 16'(mo_ff[3]);
   assign rsp_v_y = 16'(mo_ff[4]);
   assign rsp_v_z = 16'(mo_ff[5]);
   assign rsp_w_x = 16'(mo_ff[6]);
   assign rsp_w_y = 16'(mo_ff[7]);
   assign rsp_w_z = 16'(mo_ff[8]);
   assign rsp_trans_u = tr_ff[0];
   assign rsp_trans_v = tr_ff[1];
   assign rsp_trans_w = tr_ff[2];

endmodule

FILE: src/eyv_sine.sv
// Pipelined fixed-point sine of a 16-bit turn fraction, four register stages.
// Uses eyv_pkg.
module eyv_sine (
   input  logic                    clock,
   input  logic                    adv,
   input  logic [eyv_pkg::AngW-1:0] ang,
   output eyv_pkg::q14_type        sin_out
);

   logic [14:0] t_in, t1_ff, t2_ff, t3_ff;
   logic [1:0]  q1_ff, q2_ff, q3_ff;
   logic [14:0] tt_in, tt_ff, tt2_ff;
   logic [15:0] y_in, y_ff;
   logic [15:0] yy_in, yy_ff;
   logic [29:0] sq;
   logic [29:0] a1;
   logic [31:0] a2;
   logic [30:0] a3;
   logic [16:0] m;
   eyv_pkg::q14_type s_in;

   // fold the quadrant offset, then square it
   always_comb begin
      t_in  = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
      sq    = t_in * t_in + 30'd8192;
      tt_in = sq[28:14];
   end

   // first polynomial step
   always_comb begin
      a1   = tt_ff * 15'd1160 + 30'd8192;
      y_in = 16'd10512 - {3'b0, a1[26:14]};
   end

   // second polynomial step
   always_comb begin
      a2    = tt2_ff * y_ff + 32'd8192;
      yy_in = 16'd25736 - a2[29:14];
   end

   // final product, clamp and sign
   always_comb begin
      a3    = t3_ff * yy_ff + 31'd8192;
      m     = (a3[30:14] > 17'd16384) ? 17'd16384 : a3[30:14];
      s_in  = q3_ff[1] ? -eyv_pkg::q14_type'({1'b0, m}) : eyv_pkg::q14_type'({1'b0, m});
   end

   // advance the stages together
   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff   <= t_in;
         q1_ff   <= ang[15:14];
         tt_ff   <= tt_in;
         t2_ff   <= t1_ff;
         q2_ff   <= q1_ff;
         y_ff    <= y_in;
         tt2_ff  <= tt_ff;
         t3_ff   <= t2_ff;
         q3_ff   <= q2_ff;
         yy_ff   <= yy_in;
         sin_out <= s_in;
      end
   end

endmodule

FILE: src/eyv_checker.sv
// Port checker for the Euler YXZ view matrix core, bound to the top level.
// Depends only on the top level's ports.
module eyv_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_w_y,
   input logic signed [15:0] rsp_u_x,
   input logic signed [31:0] rsp_trans_u
);

   // hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_trans_u))
      else $error("stalled item changed");

   // input side stalls only while the output holds an item
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

   // the u_x and w_y entries stay within one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_w_y <= 16'sd16384) && (rsp_w_y >= -16'sd16384)
                    && (rsp_u_x <= 16'sd16384) && (rsp_u_x >= -16'sd16384))
      else $error("entry out of range");

   // no result right after reset
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result after reset");

endmodule

bind euler_yxz_view_matrix_core eyv_checker u_eyv_checker (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_w_y, .rsp_u_x, .rsp_trans_u
);

FILE: verif/tb_euler_yxz_view_matrix_core.sv
// Testbench for euler_yxz_view_matrix_core: random and directed view items,
// a fixed-point predictor and an in-order scoreboard. Needs no package.
`timescale 1ns / 100ps

module tb_euler_yxz_view_matrix_core;

   typedef struct packed {
      logic signed [15:0] ux, uy, uz, vx, vy, vz, wx, wy, wz;
      logic signed [31:0] tu, tv, tw;
   } view_type;

   // Predict the view matrix for each item and check results in order
   class view_scoreboard;
      view_type pending[$];
      int       mismatches;

      function longint rnd14(longint a, longint b);
         longint p;
         p = a * b + 8192;
         return p >>> 14;
      endfunction

      function longint sine(logic [15:0] ang);
         longint t, t2, y, m;
         t = ang[13:0];
         if (ang[14]) t = 16384 - t;
         t2 = (t * t + 8192) >>> 14;
         y = 10512 - ((t2 * 1160 + 8192) >>> 14);
         y = 25736 - ((t2 * y + 8192) >>> 14);
         m = (t * y + 8192) >>> 14;
         if (m > 16384) m = 16384;
         return ang[15] ? -m : m;
      endfunction

      function longint clip(longint x);
         if (x > 16384) return 16384;
         if (x < -16384) return -16384;
         return x;
      endfunction

      function logic signed [31:0] offset(longint a, longint b, longint c,
                                          longint px, longint py, longint pz);
         longint s;
         s = (-(a * px + b * py + c * pz) + 8192) >>> 14;
         if (s > 64'sd2147483647) s = 64'sd2147483647;
         if (s < -64'sd2147483648) s = -64'sd2147483648;
         return s[31:0];
      endfunction

      function void note_item(logic signed [31:0] px, py, pz, logic [15:0] ax, ay, az);
         longint c1, s1, c2, s2, c3, s3;
         longint e[9];
         view_type v;
         c2 = sine(ax + 16'd16384); s2 = sine(ax);
         c1 = sine(ay + 16'd16384); s1 = sine(ay);
         c3 = sine(az + 16'd16384); s3 = sine(az);
         e[0] = clip(rnd14(c1, c3) + rnd14(rnd14(s1, s2), s3));
         e[1] = clip(rnd14(c2, s3));
         e[2] = clip(rnd14(rnd14(c1, s2), s3) - rnd14(c3, s1));
         e[3] = clip(rnd14(rnd14(c3, s1), s2) - rnd14(c1, s3));
         e[4] = clip(rnd14(c2, c3));
         e[5] = clip(rnd14(rnd14(c1, c3), s2) + rnd14(s1, s3));
         e[6] = clip(rnd14(c2, s1));
         e[7] = clip(-s2);
         e[8] = clip(rnd14(c1, c2));
         v.ux = 16'(e[0]); v.uy = 16'(e[1]); v.uz = 16'(e[2]);
         v.vx = 16'(e[3]); v.vy = 16'(e[4]); v.vz = 16'(e[5]);
         v.wx = 16'(e[6]); v.wy = 16'(e[7]); v.wz = 16'(e[8]);
         v.tu = offset(e[0], e[1], e[2], px, py, pz);
         v.tv = offset(e[3], e[4], e[5], px, py, pz);
         v.tw = offset(e[6], e[7], e[8], px, py, pz);
         pending.push_back(v);
      endfunction

      function void check_result(view_type got);
         view_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %h actual %h", want, got);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, rsp_valid, rsp_ready = 0;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic [15:0] req_angle_x = 0, req_angle_y = 0, req_angle_z = 0;
   logic signed [15:0] rsp_u_x, rsp_u_y, rsp_u_z, rsp_v_x, rsp_v_y, rsp_v_z;
   logic signed [15:0] rsp_w_x, rsp_w_y, rsp_w_z;
   logic signed [31:0] rsp_trans_u, rsp_trans_v, rsp_trans_w;
   view_scoreboard board = new();
   int cycles = 0;

   euler_yxz_view_matrix_core DUT (
      .clock, .reset, .req_valid, .req_ready, .req_pos_x, .req_pos_y, .req_pos_z,
      .req_angle_x, .req_angle_y, .req_angle_z, .rsp_valid, .rsp_ready,
      .rsp_u_x, .rsp_u_y, .rsp_u_z, .rsp_v_x, .rsp_v_y, .rsp_v_z,
      .rsp_w_x, .rsp_w_y, .rsp_w_z, .rsp_trans_u, .rsp_trans_v, .rsp_trans_w);

   always #5 clock = ~clock;

   function automatic int gap_len();
      return ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(2);
   endfunction

   // Sample handshakes and watch for a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_valid && req_ready)
         board.note_item(req_pos_x, req_pos_y, req_pos_z, req_angle_x, req_angle_y,
                         req_angle_z);
      if (!reset && rsp_valid && rsp_ready)
         board.check_result({rsp_u_x, rsp_u_y, rsp_u_z, rsp_v_x, rsp_v_y, rsp_v_z,
                             rsp_w_x, rsp_w_y, rsp_w_z,
                             rsp_trans_u, rsp_trans_v, rsp_trans_w});
      if (cycles > 400000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Stall the result side at random, with quiet stretches
   initial begin
      int n;
      forever begin
         @(posedge clock);
         n = ($urandom_range(3) == 0) ? 0 : gap_len();
         if (n > 0) begin
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1;
      end
   end

   // Hold one item until it is accepted
   task automatic send_view(logic [31:0] px, py, pz, logic [15:0] ax, ay, az, bit idle);
      int n;
      n = idle ? gap_len() : 0;
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_pos_x <= px; req_pos_y <= py; req_pos_z <= pz;
      req_angle_x <= ax; req_angle_y <= ay; req_angle_z <= az;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [31:0] rpos();
      case ($urandom_range(3))
         0: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1: return $urandom_range(32'h3_0000) - 32'h1_8000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] rang();
      logic [15:0] a;
      a = 16'($urandom);
      if ($urandom_range(3) == 0) a[13:0] = $urandom_range(1) ? 14'h0 : 14'h3FFF;
      return a;
   endfunction

   initial begin
      logic [15:0] quad[8];
      quad = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
               16'hFFFF, 16'h3FFF, 16'h2000, 16'h0001};
      repeat (12) @(posedge clock);
      reset <= 0;
      // Directed: quadrant edges and saturating positions
      for (int i = 0; i < 8; i++)
         send_view(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000,
                   quad[i], quad[(i + 3) % 8], quad[(i + 5) % 8], 1'b0);
      send_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                16'h2000, 16'h2000, 16'h2000, 1'b0);
      send_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                16'hE000, 16'h6000, 16'hA000, 1'b0);
      send_view(32'h0, 32'h0, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      // Random items
      for (int i = 0; i < 800; i++) begin
         if (i == 400) begin
            // Let the pipeline drain fully before going on
            req_valid <= 0;
            wait (board.pending.size() == 0);
            @(posedge clock);
         end
         send_view(rpos(), rpos(), rpos(), rang(), rang(), rang(),
                   1'($urandom_range(1)));
      end
      req_valid <= 0;
      wait (board.pending.size() == 0);
      repeat (20) @(posedge clock);
      if (board.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
